FILE: src/stok_pkg.sv
`default_nettype none
package stok_pkg;

  localparam int POS_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int NUM_KW          = 13;

  // token kinds
  localparam logic [5:0] K_LPAREN     = 6'd0;
  localparam logic [5:0] K_RPAREN     = 6'd1;
  localparam logic [5:0] K_LBRACE     = 6'd2;
  localparam logic [5:0] K_RBRACE     = 6'd3;
  localparam logic [5:0] K_COMMA      = 6'd4;
  localparam logic [5:0] K_DOT        = 6'd5;
  localparam logic [5:0] K_MINUS      = 6'd6;
  localparam logic [5:0] K_PLUS       = 6'd7;
  localparam logic [5:0] K_SEMI       = 6'd8;
  localparam logic [5:0] K_SLASH      = 6'd9;
  localparam logic [5:0] K_STAR       = 6'd10;
  localparam logic [5:0] K_BANG       = 6'd11;
  localparam logic [5:0] K_EQUAL      = 6'd13;
  localparam logic [5:0] K_GREATER    = 6'd15;
  localparam logic [5:0] K_LESS       = 6'd17;
  localparam logic [5:0] K_IDENT      = 6'd19;
  localparam logic [5:0] K_STRING     = 6'd20;
  localparam logic [5:0] K_NUMBER     = 6'd21;
  localparam logic [5:0] K_KEYWORD0   = 6'd22;
  localparam logic [5:0] K_EOF        = 6'd35;
  localparam logic [5:0] K_ERR_CHAR   = 6'd36;
  localparam logic [5:0] K_ERR_STRING = 6'd37;

  typedef struct packed {
    logic [15:0] length;
    logic [15:0] start_pos;
    logic [5:0]  kind;
  } token_t;

  // tokens caused by one source byte
  typedef struct packed {
    logic   two;
    token_t t1;
    token_t t0;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] i);
    case (i)
      4'd0:    kw_len = 3'd3;
      4'd1:    kw_len = 3'd2;
      4'd2:    kw_len = 3'd2;
      4'd3:    kw_len = 3'd4;
      4'd4:    kw_len = 3'd3;
      4'd5:    kw_len = 3'd5;
      4'd6:    kw_len = 3'd6;
      4'd7:    kw_len = 3'd4;
      4'd8:    kw_len = 3'd5;
      4'd9:    kw_len = 3'd3;
      4'd10:   kw_len = 3'd3;
      4'd11:   kw_len = 3'd3;
      4'd12:   kw_len = 3'd5;
      default: kw_len = 3'd0;
    endcase
  endfunction

  // character p of keyword i, words right-justified with first char highest
  function automatic logic [7:0] kw_char(input logic [3:0] i, input logic [2:0] p);
    logic [47:0] word;
    logic [2:0]  sh;
    case (i)
      4'd0:    word = 48'("and");
      4'd1:    word = 48'("or");
      4'd2:    word = 48'("if");
      4'd3:    word = 48'("else");
      4'd4:    word = 48'("for");
      4'd5:    word = 48'("while");
      4'd6:    word = 48'("return");
      4'd7:    word = 48'("true");
      4'd8:    word = 48'("false");
      4'd9:    word = 48'("fun");
      4'd10:   word = 48'("nil");
      4'd11:   word = 48'("var");
      4'd12:   word = 48'("print");
      default: word = 48'd0;
    endcase
    sh = kw_len(i) - 3'd1 - p;
    kw_char = word[{sh, 3'b000} +: 8];
  endfunction

  function automatic logic [NUM_KW-1:0] kw_update(input logic [NUM_KW-1:0] cand,
                                                  input logic [7:0] c,
                                                  input logic [2:0] idx);
    logic [NUM_KW-1:0] keep;
    keep = '0;
    for (int i = 0; i < NUM_KW; i++) begin
      keep[i] = cand[i] && (idx < kw_len(4'(i))) && (kw_char(4'(i), idx) == c);
    end
    kw_update = keep;
  endfunction

endpackage
`default_nettype wire

FILE: src/stok_front.sv
`default_nettype none
module stok_front #(
  parameter int POS_BITS = stok_pkg::POS_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  wire [7:0]            ch,
  output logic                 push,
  output stok_pkg::bundle_t    bundle
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_BANG    = 4'd3;
  localparam logic [3:0] M_EQUAL   = 4'd4;
  localparam logic [3:0] M_LESS    = 4'd5;
  localparam logic [3:0] M_GREATER = 4'd6;
  localparam logic [3:0] M_STRING  = 4'd7;
  localparam logic [3:0] M_INT     = 4'd8;
  localparam logic [3:0] M_FRAC    = 4'd9;
  localparam logic [3:0] M_IDENT   = 4'd10;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] KW_IDX_LIMIT = POS_BITS'(6);

  logic [3:0]                   mode, mode_next;
  logic [POS_BITS-1:0]          position, position_next;
  logic [POS_BITS-1:0]          token_start, token_start_next;
  logic [stok_pkg::NUM_KW-1:0]  cand, cand_next;

  logic [POS_BITS-1:0] pos_inc, pend, span;
  logic                fire, again, is_eof, is_digit, is_alpha;
  logic                a_v, b_v;
  logic [5:0]          a_kind, b_kind, single, id_kind;
  logic [POS_BITS-1:0] a_len, b_len, b_start;
  stok_pkg::token_t    tok_a, tok_b;

  assign fire     = in_valid && in_ready;
  assign pos_inc  = (position == POS_MAX) ? position : position + 1'b1;
  assign pend     = position - token_start;
  assign span     = pos_inc - token_start;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_alpha = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ||
                    ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) || (ch == CH_UNDER);

  // first matching keyword of the right length, else plain identifier
  always_comb begin
    id_kind = stok_pkg::K_IDENT;
    for (int i = stok_pkg::NUM_KW - 1; i >= 0; i--) begin
      if (cand[i] && (pend == POS_BITS'(stok_pkg::kw_len(4'(i))))) begin
        id_kind = 6'(stok_pkg::K_KEYWORD0 + 6'(i));
      end
    end
  end

  always_comb begin
    mode_next        = mode;
    token_start_next = token_start;
    cand_next        = cand;
    again            = 1'b1;
    is_eof           = 1'b0;
    a_v              = 1'b0;
    a_kind           = stok_pkg::K_IDENT;
    a_len            = pend;
    b_v              = 1'b0;
    b_kind           = stok_pkg::K_ERR_CHAR;
    b_len            = POS_BITS'(1);
    b_start          = position;
    single           = 6'd0;

    // finish or extend the pending token
    case (mode)
      M_SLASH: begin
        if (ch == CH_SLASH) begin
          mode_next = M_COMMENT;
          again     = 1'b0;
        end else begin
          a_v    = 1'b1;
          a_kind = stok_pkg::K_SLASH;
        end
      end
      M_BANG:    single = stok_pkg::K_BANG;
      M_EQUAL:   single = stok_pkg::K_EQUAL;
      M_LESS:    single = stok_pkg::K_LESS;
      M_GREATER: single = stok_pkg::K_GREATER;
      M_COMMENT: begin
        if (ch == CH_NL) mode_next = M_IDLE;
        if (ch != CH_NUL) again = 1'b0;
      end
      M_STRING: begin
        if (ch == CH_QUOTE) begin
          a_v       = 1'b1;
          a_kind    = stok_pkg::K_STRING;
          a_len     = span;
          mode_next = M_IDLE;
          again     = 1'b0;
        end else if (ch == CH_NUL) begin
          a_v    = 1'b1;
          a_kind = stok_pkg::K_ERR_STRING;
        end else begin
          again = 1'b0;
        end
      end
      M_INT: begin
        if (is_digit) begin
          again = 1'b0;
        end else if (ch == CH_DOT) begin
          mode_next = M_FRAC;
          again     = 1'b0;
        end else begin
          a_v    = 1'b1;
          a_kind = stok_pkg::K_NUMBER;
        end
      end
      M_FRAC: begin
        if (is_digit) begin
          again = 1'b0;
        end else begin
          a_v    = 1'b1;
          a_kind = stok_pkg::K_NUMBER;
        end
      end
      M_IDENT: begin
        if (is_alpha || is_digit) begin
          cand_next = (pend < KW_IDX_LIMIT) ?
                      stok_pkg::kw_update(cand, ch, pend[2:0]) : '0;
          again     = 1'b0;
        end else begin
          a_v    = 1'b1;
          a_kind = id_kind;
        end
      end
      default: ;
    endcase

    // operators that may take a trailing '='
    if (single != 6'd0) begin
      a_v = 1'b1;
      if (ch == CH_EQUAL) begin
        a_kind    = 6'(single + 6'd1);
        a_len     = span;
        mode_next = M_IDLE;
        again     = 1'b0;
      end else begin
        a_kind = single;
      end
    end

    // byte seen between tokens
    if (again) begin
      mode_next = M_IDLE;
      case (ch)
        CH_NUL: begin
          b_v    = 1'b1;
          b_kind = stok_pkg::K_EOF;
          b_len  = '0;
          is_eof = 1'b1;
        end
        CH_SPACE, CH_CR, CH_TAB, CH_NL: ;
        CH_LPAREN: begin b_v = 1'b1; b_kind = stok_pkg::K_LPAREN; end
        CH_RPAREN: begin b_v = 1'b1; b_kind = stok_pkg::K_RPAREN; end
        CH_LBRACE: begin b_v = 1'b1; b_kind = stok_pkg::K_LBRACE; end
        CH_RBRACE: begin b_v = 1'b1; b_kind = stok_pkg::K_RBRACE; end
        CH_COMMA:  begin b_v = 1'b1; b_kind = stok_pkg::K_COMMA;  end
        CH_DOT:    begin b_v = 1'b1; b_kind = stok_pkg::K_DOT;    end
        CH_MINUS:  begin b_v = 1'b1; b_kind = stok_pkg::K_MINUS;  end
        CH_PLUS:   begin b_v = 1'b1; b_kind = stok_pkg::K_PLUS;   end
        CH_SEMI:   begin b_v = 1'b1; b_kind = stok_pkg::K_SEMI;   end
        CH_STAR:   begin b_v = 1'b1; b_kind = stok_pkg::K_STAR;   end
        CH_SLASH:  begin token_start_next = position; mode_next = M_SLASH;   end
        CH_BANG:   begin token_start_next = position; mode_next = M_BANG;    end
        CH_EQUAL:  begin token_start_next = position; mode_next = M_EQUAL;   end
        CH_LESS:   begin token_start_next = position; mode_next = M_LESS;    end
        CH_GREAT:  begin token_start_next = position; mode_next = M_GREATER; end
        CH_QUOTE:  begin token_start_next = position; mode_next = M_STRING;  end
        default: begin
          if (is_digit) begin
            token_start_next = position;
            mode_next        = M_INT;
          end else if (is_alpha) begin
            token_start_next = position;
            mode_next        = M_IDENT;
            cand_next        = stok_pkg::kw_update('1, ch, 3'd0);
          end else begin
            b_v = 1'b1;
          end
        end
      endcase
    end

    position_next = pos_inc;
    if (is_eof) begin
      mode_next        = M_IDLE;
      position_next    = '0;
      token_start_next = '0;
      cand_next        = '0;
    end
  end

  always_comb begin
    tok_a.kind      = a_kind;
    tok_a.start_pos = stok_pkg::sat16(32'(token_start));
    tok_a.length    = stok_pkg::sat16(32'(a_len));
    tok_b.kind      = b_kind;
    tok_b.start_pos = stok_pkg::sat16(32'(b_start));
    tok_b.length    = stok_pkg::sat16(32'(b_len));
    bundle.two      = a_v && b_v;
    bundle.t0       = a_v ? tok_a : tok_b;
    bundle.t1       = tok_b;
  end

  assign push = fire && (a_v || b_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      position    <= '0;
      token_start <= '0;
      cand        <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      position    <= position_next;
      token_start <= token_start_next;
      cand        <= cand_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/stok_fifo.sv
`default_nettype none
module stok_fifo #(
  parameter int DEPTH = stok_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  stok_pkg::bundle_t       wr_data,
  input  wire                     pop,
  output stok_pkg::bundle_t       rd_data,
  output stok_pkg::queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  stok_pkg::bundle_t mem [DEPTH];
  logic [AW-1:0]     head, tail;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign status.valid = (count != '0);
  assign status.full  = (count == CW'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign rd_data      = mem[head];

  always_ff @(posedge clk) begin
    if (do_push) mem[tail] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      if (do_pop)  head <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/stok_back.sv
`default_nettype none
module stok_back (
  input  wire                     clk,
  input  wire                     rst,
  input  stok_pkg::bundle_t       q_data,
  input  stok_pkg::queue_status_t q_status,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output stok_pkg::token_t        out_token,
  output logic                    out_last
);

  stok_pkg::bundle_t held;
  logic              held_valid;
  logic              sel;
  logic              fire, done;

  assign out_valid = held_valid;
  assign out_token = sel ? held.t1 : held.t0;
  assign out_last  = !held.two || sel;
  assign fire      = out_valid && out_ready;
  assign done      = fire && out_last;
  assign q_pop     = q_status.valid && (!held_valid || done);

  always_ff @(posedge clk) begin
    if (q_pop) held <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (q_pop) begin
      held_valid <= 1'b1;
      sel        <= 1'b0;
    end else if (done) begin
      held_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (fire) begin
      // second token of the pair follows
      sel <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/script_token_scanner_core.sv
// path: a token caused by an accepted byte is written into the queue, then
//   loaded into the output register, from which it is offered on the output
// throughput: one source byte per cycle while the queue is not full; a byte
//   that ends one token and starts another yields two tokens, sent as two output transfers
// reset: synchronous, clears scanner state and position, empties the queue
`default_nettype none
module script_token_scanner_core #(
  parameter int POS_BITS    = stok_pkg::POS_BITS_DEF,
  parameter int QUEUE_DEPTH = stok_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,  // [7:0] ch
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,  // [5:0] kind, [21:6] start_pos, [37:22] length, zero pad
  output logic        m_tlast
);

  stok_pkg::bundle_t       f_bundle, q_data;
  stok_pkg::queue_status_t q_status;
  stok_pkg::token_t        tok;
  logic                    q_push, q_pop;

  assign s_tready = !q_status.full;

  stok_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .ch       (s_tdata),
    .push     (q_push),
    .bundle   (f_bundle)
  );

  stok_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (f_bundle),
    .pop     (q_pop),
    .rd_data (q_data),
    .status  (q_status)
  );

  stok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_token (tok),
    .out_last  (m_tlast)
  );

  assign m_tdata = {2'b00, tok.length, tok.start_pos, tok.kind};

  // end of source always produces at least the eof token
  a_eof_pushes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tdata == 8'd0)) |-> q_push)
    else $error("end of source produced no token");

  // the second token of a pair stays offered after the first
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("second token of a pair lost");

  // a full queue is never empty
  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> q_status.valid)
    else $error("queue status inconsistent");

endmodule
`default_nettype wire

FILE: tb/script_token_scanner_core_tb.sv
`timescale 1ns / 100ps
module script_token_scanner_core_tb;

  localparam int unsigned POS_MAX = 65535;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT = 200;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;

  // two-char forms sit one above their single-char kind
  localparam logic [5:0] KIND_BANG_EQ = stok_pkg::K_BANG + 6'd1;

  typedef enum logic [3:0] {
    SC_IDLE, SC_SLASH, SC_COMMENT, SC_BANG, SC_EQUAL, SC_LESS, SC_GREATER,
    SC_STRING, SC_INT, SC_FRAC, SC_IDENT
  } scan_mode_e;

  typedef enum {
    SH_KEYWORD, SH_KW_PREFIX, SH_IDENT, SH_NUMBER, SH_STRING, SH_PUNCT,
    SH_OPERATOR, SH_COMMENT, SH_SPACE, SH_BAD_CHAR, SH_NOISE, SH_COUNT
  } shape_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] length;
    logic        last;
  } scan_tok_t;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    int         cnt;
    scan_tok_t  t0;
    scan_tok_t  t1;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  script_token_scanner_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // scanner prediction state
  scan_mode_e  sc_mode = SC_IDLE;
  int unsigned sc_pos = 0;
  int unsigned sc_start = 0;
  logic [12:0] sc_cand = '0;
  scan_tok_t   byte_toks [2];
  int          byte_ntok;

  scan_tok_t   tokens_due [$];
  logic [7:0]  src_text [$];
  dir_row_t    dir_rows [$];
  logic [7:0]  spaces [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  bit          src_gaps = 1'b0;
  bit          sink_gaps = 1'b0;
  int          mismatch_count = 0;
  int          tokens_checked = 0;
  int          bytes_fed = 0;
  int          quiet_cycles = 0;
  logic [63:0] kind_seen = '0;

  function automatic string kw_word(int i);
    case (i)
      0:  return "and";
      1:  return "or";
      2:  return "if";
      3:  return "else";
      4:  return "for";
      5:  return "while";
      6:  return "return";
      7:  return "true";
      8:  return "false";
      9:  return "fun";
      10: return "nil";
      11: return "var";
      12: return "print";
      default: return "";
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // keep only keywords whose character at idx equals c
  function automatic logic [12:0] narrow_cand(logic [12:0] cur, logic [7:0] c,
                                              int unsigned idx);
    logic [12:0] keep;
    string       w;
    keep = '0;
    for (int i = 0; i < stok_pkg::NUM_KW; i++) begin
      w = kw_word(i);
      if (cur[i] && idx < 6 && idx < w.len() && w[idx] == c) keep[i] = 1'b1;
    end
    return keep;
  endfunction

  function automatic logic [5:0] ident_kind();
    int unsigned len;
    string       w;
    len = sc_pos - sc_start;
    for (int i = 0; i < stok_pkg::NUM_KW; i++) begin
      w = kw_word(i);
      if (sc_cand[i] && w.len() == len) return stok_pkg::K_KEYWORD0 + 6'(i);
    end
    return stok_pkg::K_IDENT;
  endfunction

  function automatic void put_tok(logic [5:0] k, int unsigned s, int unsigned len);
    if (byte_ntok < 2) begin
      byte_toks[byte_ntok] = '{kind: k, start_pos: 16'(s), length: 16'(len), last: 1'b0};
      byte_ntok++;
    end
  endfunction

  function automatic void scan_clear();
    sc_mode = SC_IDLE;
    sc_pos = 0;
    sc_start = 0;
    sc_cand = '0;
  endfunction

  // byte seen between tokens; returns 1 at end of source
  function automatic bit scan_idle(logic [7:0] c);
    sc_mode = SC_IDLE;
    if (c == CH_NUL) begin
      put_tok(stok_pkg::K_EOF, sc_pos, 0);
      return 1'b1;
    end
    if (is_space(c)) return 1'b0;
    if (is_digit(c)) begin
      sc_start = sc_pos;
      sc_mode = SC_INT;
      return 1'b0;
    end
    if (is_alpha(c)) begin
      sc_start = sc_pos;
      sc_mode = SC_IDENT;
      sc_cand = narrow_cand('1, c, 0);
      return 1'b0;
    end
    case (c)
      "(": put_tok(stok_pkg::K_LPAREN, sc_pos, 1);
      ")": put_tok(stok_pkg::K_RPAREN, sc_pos, 1);
      "{": put_tok(stok_pkg::K_LBRACE, sc_pos, 1);
      "}": put_tok(stok_pkg::K_RBRACE, sc_pos, 1);
      ",": put_tok(stok_pkg::K_COMMA, sc_pos, 1);
      ".": put_tok(stok_pkg::K_DOT, sc_pos, 1);
      "-": put_tok(stok_pkg::K_MINUS, sc_pos, 1);
      "+": put_tok(stok_pkg::K_PLUS, sc_pos, 1);
      ";": put_tok(stok_pkg::K_SEMI, sc_pos, 1);
      "*": put_tok(stok_pkg::K_STAR, sc_pos, 1);
      "/": begin sc_start = sc_pos; sc_mode = SC_SLASH; end
      "!": begin sc_start = sc_pos; sc_mode = SC_BANG; end
      "=": begin sc_start = sc_pos; sc_mode = SC_EQUAL; end
      "<": begin sc_start = sc_pos; sc_mode = SC_LESS; end
      ">": begin sc_start = sc_pos; sc_mode = SC_GREATER; end
      CH_QUOTE: begin sc_start = sc_pos; sc_mode = SC_STRING; end
      default: put_tok(stok_pkg::K_ERR_CHAR, sc_pos, 1);
    endcase
    return 1'b0;
  endfunction

  // advance the scanner by one byte, leaving its tokens in byte_toks
  function automatic void scan_byte(logic [7:0] c);
    int unsigned nxt;
    int unsigned pend;
    bit          again;
    bit          eof;
    bit          pair;
    logic [5:0]  pair_kind;
    nxt = (sc_pos < POS_MAX) ? sc_pos + 1 : POS_MAX;
    pend = sc_pos - sc_start;
    byte_ntok = 0;
    again = 1'b1;
    eof = 1'b0;
    pair = 1'b0;
    pair_kind = stok_pkg::K_BANG;
    case (sc_mode)
      SC_SLASH:
        if (c == "/") begin
          sc_mode = SC_COMMENT;
          again = 1'b0;
        end else put_tok(stok_pkg::K_SLASH, sc_start, pend);
      SC_BANG:    begin pair = 1'b1; pair_kind = stok_pkg::K_BANG; end
      SC_EQUAL:   begin pair = 1'b1; pair_kind = stok_pkg::K_EQUAL; end
      SC_LESS:    begin pair = 1'b1; pair_kind = stok_pkg::K_LESS; end
      SC_GREATER: begin pair = 1'b1; pair_kind = stok_pkg::K_GREATER; end
      SC_COMMENT: begin
        if (c == CH_LF) sc_mode = SC_IDLE;
        if (c != CH_NUL) again = 1'b0;
      end
      SC_STRING:
        if (c == CH_QUOTE) begin
          put_tok(stok_pkg::K_STRING, sc_start, nxt - sc_start);
          sc_mode = SC_IDLE;
          again = 1'b0;
        end else if (c == CH_NUL) put_tok(stok_pkg::K_ERR_STRING, sc_start, pend);
        else again = 1'b0;
      SC_INT:
        if (is_digit(c)) again = 1'b0;
        else if (c == ".") begin
          sc_mode = SC_FRAC;
          again = 1'b0;
        end else put_tok(stok_pkg::K_NUMBER, sc_start, pend);
      SC_FRAC:
        if (is_digit(c)) again = 1'b0;
        else put_tok(stok_pkg::K_NUMBER, sc_start, pend);
      SC_IDENT:
        if (is_alpha(c) || is_digit(c)) begin
          sc_cand = narrow_cand(sc_cand, c, pend);
          again = 1'b0;
        end else put_tok(ident_kind(), sc_start, pend);
      default: ;
    endcase
    if (pair) begin
      if (c == "=") begin
        put_tok(pair_kind + 6'd1, sc_start, nxt - sc_start);
        sc_mode = SC_IDLE;
        again = 1'b0;
      end else put_tok(pair_kind, sc_start, pend);
    end
    if (again) eof = scan_idle(c);
    if (eof) scan_clear();
    else sc_pos = nxt;
    if (byte_ntok > 0) byte_toks[byte_ntok - 1].last = 1'b1;
  endfunction

  function automatic scan_tok_t tk(logic [5:0] k, int unsigned s, int unsigned len);
    return '{kind: k, start_pos: 16'(s), length: 16'(len), last: 1'b0};
  endfunction

  function automatic void row_pred(logic [7:0] c);
    dir_row_t r;
    r.ch = c;
    r.typed = 1'b0;
    r.cnt = 0;
    r.t0 = '0;
    r.t1 = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_typed(logic [7:0] c, int cnt, scan_tok_t a, scan_tok_t b);
    dir_row_t r;
    r.ch = c;
    r.typed = 1'b1;
    r.cnt = cnt;
    r.t0 = a;
    r.t1 = b;
    if (cnt == 1) r.t0.last = 1'b1;
    else r.t1.last = 1'b1;
    dir_rows.push_back(r);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_alnum(bit digits_ok);
    int r;
    r = $urandom_range(0, digits_ok ? 62 : 52);
    if (r < 26) return CH_LOWER_A + 8'(r);
    if (r < 52) return CH_UPPER_A + 8'(r - 26);
    if (r == 52) return CH_UNDERSCORE;
    return CH_ZERO + 8'(r - 53);
  endfunction

  function automatic logic [7:0] rand_text_byte(logic [7:0] excl);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    return (c == excl) ? CH_SPACE : c;
  endfunction

  function automatic bit starts_token(logic [7:0] c);
    string marks;
    marks = "(){},.-+;*/!=<>";
    if (is_digit(c) || is_alpha(c) || is_space(c) || c == CH_QUOTE) return 1'b1;
    for (int i = 0; i < marks.len(); i++)
      if (marks[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  // appends one random lexeme; returns its byte count unless it is skipped text
  function automatic int put_rand_token();
    int     n0;
    shape_e shape;
    string  w;
    string  marks;
    logic [7:0] c;
    n0 = src_text.size();
    shape = shape_e'($urandom_range(0, SH_COUNT - 1));
    case (shape)
      SH_KEYWORD: put_text(kw_word($urandom_range(0, stok_pkg::NUM_KW - 1)));
      SH_KW_PREFIX: begin
        w = kw_word($urandom_range(0, stok_pkg::NUM_KW - 1));
        put_text(w.substr(0, $urandom_range(0, w.len() - 1)));
        repeat ($urandom_range(0, 2)) src_text.push_back(rand_alnum(1'b1));
      end
      SH_IDENT: begin
        src_text.push_back(rand_alnum(1'b0));
        repeat ($urandom_range(0, 7)) src_text.push_back(rand_alnum(1'b1));
      end
      SH_NUMBER: begin
        repeat ($urandom_range(1, 5)) src_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          src_text.push_back(".");
          repeat ($urandom_range(0, 3)) src_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      SH_STRING: begin
        src_text.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 10)) src_text.push_back(rand_text_byte(CH_QUOTE));
        src_text.push_back(CH_QUOTE);
      end
      SH_PUNCT: begin
        marks = "(){},.-+;*/";
        src_text.push_back(marks[$urandom_range(0, marks.len() - 1)]);
      end
      SH_OPERATOR: begin
        marks = "!=<>";
        src_text.push_back(marks[$urandom_range(0, 3)]);
        if ($urandom_range(0, 1)) src_text.push_back("=");
      end
      SH_COMMENT: begin
        put_text("//");
        repeat ($urandom_range(0, 10)) src_text.push_back(rand_text_byte(CH_LF));
        src_text.push_back(CH_LF);
      end
      SH_SPACE: repeat ($urandom_range(1, 3)) src_text.push_back(spaces[$urandom_range(0, 3)]);
      SH_BAD_CHAR: begin
        do c = 8'($urandom_range(1, 255)); while (starts_token(c));
        src_text.push_back(c);
      end
      default: src_text.push_back(8'($urandom_range(1, 255)));
    endcase
    return (shape == SH_COMMENT || shape == SH_SPACE) ? 0 : src_text.size() - n0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_token(input logic [39:0] data, input logic tl);
    scan_tok_t seen;
    scan_tok_t want;
    seen = '{kind: data[5:0], start_pos: data[21:6], length: data[37:22], last: tl};
    kind_seen[seen.kind] = 1'b1;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("token kind %0d at %0d with none expected",
                                seen.kind, seen.start_pos));
      return;
    end
    want = tokens_due.pop_front();
    tokens_checked++;
    if (seen.kind != want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", seen.kind, want.kind));
    if (seen.start_pos != want.start_pos)
      report_mismatch($sformatf("start_pos %0d, expected %0d (kind %0d)",
                                seen.start_pos, want.start_pos, want.kind));
    if (seen.length != want.length)
      report_mismatch($sformatf("length %0d, expected %0d (kind %0d)",
                                seen.length, want.length, want.kind));
    if (seen.last != want.last)
      report_mismatch($sformatf("last %0b, expected %0b (kind %0d)",
                                seen.last, want.last, want.kind));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_token(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver with random back-pressure
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (sink_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] c, input bit predict);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tdata  <= c;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_fed++;
    scan_byte(c);
    if (predict)
      for (int i = 0; i < byte_ntok; i++) tokens_due.push_back(byte_toks[i]);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tokens_due.size() != 0);
  endtask

  task automatic send_text();
    foreach (src_text[i]) send_byte(src_text[i], 1'b1);
  endtask

  task automatic run_programs(input int goal, input bit allow_gaps);
    while (bytes_fed < goal) begin
      src_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
      sink_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
      src_text.delete();
      if ($urandom_range(0, 9) == 0) begin
        // raw noise
        repeat ($urandom_range(5, 30)) src_text.push_back(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(3, 16)) begin
          void'(put_rand_token());
          if ($urandom_range(0, 1)) src_text.push_back(spaces[$urandom_range(0, 3)]);
        end
        if ($urandom_range(0, 9) == 0) begin
          // string left open at end of source
          src_text.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) src_text.push_back(rand_text_byte(CH_QUOTE));
        end else if ($urandom_range(0, 9) == 0) begin
          put_text("//");
          repeat ($urandom_range(0, 6)) src_text.push_back(rand_text_byte(CH_LF));
        end
      end
      src_text.push_back(CH_NUL);
      send_text();
      if (allow_gaps && $urandom_range(0, 5) == 0) hold_until_drained();
    end
  endtask

  initial begin
    dir_row_t r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed source: ( 0xff != 1.. and // x <lf> "<lf>q <nul> < <nul> // <nul>
    row_typed("(", 1, tk(stok_pkg::K_LPAREN, 0, 1), '0);
    row_typed(8'hFF, 1, tk(stok_pkg::K_ERR_CHAR, 1, 1), '0);
    row_pred("!");
    row_typed("=", 1, tk(KIND_BANG_EQ, 2, 2), '0);
    row_pred("1");
    row_pred(".");
    row_pred(".");
    row_pred("a");
    row_pred("n");
    row_pred("d");
    row_pred(CH_SPACE);
    row_pred("/");
    row_pred("/");
    row_pred("x");
    row_pred(CH_LF);
    row_pred(CH_QUOTE);
    row_pred(CH_LF);
    row_pred("q");
    row_typed(CH_NUL, 2, tk(stok_pkg::K_ERR_STRING, 15, 3), tk(stok_pkg::K_EOF, 18, 0));
    row_pred("<");
    row_typed(CH_NUL, 2, tk(stok_pkg::K_LESS, 0, 1), tk(stok_pkg::K_EOF, 1, 0));
    row_pred("/");
    row_pred("/");
    row_typed(CH_NUL, 1, tk(stok_pkg::K_EOF, 2, 0), '0);

    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_byte(r.ch, !r.typed);
      if (r.typed) begin
        tokens_due.push_back(r.t0);
        if (r.cnt == 2) tokens_due.push_back(r.t1);
      end
    end
    hold_until_drained();

    run_programs(480, 1'b1);
    hold_until_drained();

    run_programs(600, 1'b0);

    s_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("fed %0d source bytes, checked %0d tokens, saw %0d of 38 token kinds",
             bytes_fed, tokens_checked, $countones(kind_seen));
    $display("included open strings and comments at end of source and stalls on both sides");
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/stok_pkg.sv
src/stok_front.sv
src/stok_fifo.sv
src/stok_back.sv
src/script_token_scanner_core.sv
tb/script_token_scanner_core_tb.sv
